// ----- sv/fqrk_pkg.sv -----
// ----------------------------------------------------------------------------
// fqrk_pkg
// Shared types and codes for the keyed FIFO queue with removal by key.
// ----------------------------------------------------------------------------
package fqrk_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOKEY = 2'd3
  } status_t;

  // Broadcast from the queue controller to every cell
  typedef struct packed {
    logic push_en;    // load the input item into the tail cell
    logic remove_en;  // compare keys, close up behind the first hit
  } cell_ctl_t;

endpackage

// ----- sv/fqrk_if.sv -----
// ----------------------------------------------------------------------------
// fqrk_if
// Valid/ready channels for the command input and the result output.
// ----------------------------------------------------------------------------
interface fqrk_in_if #(
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic [KEY_BITS-1:0]     key_pid;
  logic [PAYLOAD_BITS-1:0] entry_payload;

  modport source (output valid, cmd, key_pid, entry_payload, input ready);
  modport sink   (input valid, cmd, key_pid, entry_payload, output ready);
endinterface

interface fqrk_out_if #(
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int COUNT_BITS   = 5
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [COUNT_BITS-1:0]   occupancy;
  logic                    head_valid;
  logic [KEY_BITS-1:0]     head_key;
  logic [PAYLOAD_BITS-1:0] head_data;

  modport source (output valid, status, occupancy, head_valid, head_key, head_data,
                  input ready);
  modport sink   (input valid, status, occupancy, head_valid, head_key, head_data,
                  output ready);
endinterface

// ----- sv/fqrk_cell.sv -----
// ----------------------------------------------------------------------------
// fqrk_cell
// One queue slot: holds a key and payload, loads a pushed item when it is
// the tail, or takes its right-hand neighbour's entry when closing up.
// ----------------------------------------------------------------------------
module fqrk_cell
  import fqrk_pkg::*;
#(
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic                    occ,      // slot holds a live entry
  input  logic                    tail,     // first free slot
  input  logic                    hit_in,   // a slot nearer the head is removed
  input  logic [KEY_BITS-1:0]     in_key,
  input  logic [PAYLOAD_BITS-1:0] in_data,
  input  logic [KEY_BITS-1:0]     nb_key,
  input  logic [PAYLOAD_BITS-1:0] nb_data,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [PAYLOAD_BITS-1:0] data_o,
  output logic                    hit_out
);

  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] data_r;
  logic                    match;

  assign match   = ctl.remove_en && occ && (key_r == in_key);
  assign hit_out = hit_in || match;
  assign key_o   = key_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (ctl.push_en && tail) begin
      key_r  <= in_key;
      data_r <= in_data;
    end else if (hit_out) begin
      key_r  <= nb_key;
      data_r <= nb_data;
    end
  end

endmodule

// ----- sv/fifo_queue_with_remove_by_key.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_key
// Bounded ordered queue with push, pop and delete-first-match by key.
// ----------------------------------------------------------------------------
// Takes one command per clock. Each accepted item updates the row of cells at
// that edge and its result (status, occupancy, head entry) appears registered
// on the next cycle; a new item is taken whenever the result register is
// empty or being read. Each cell compares its own key; the first-match flag
// ripples along the row, so the key compare plus the QUEUE_DEPTH-long match
// chain sets the clock period. No clearing pass is needed after reset.
module fifo_queue_with_remove_by_key
  import fqrk_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  fqrk_in_if.sink          in_if,
  fqrk_out_if.source       out_if
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]           count_r, count_nxt;
  logic                    out_valid_r;
  status_t                 status_r, status_nxt;

  logic                    accept;
  cmd_t                    cmd;
  logic                    empty, full, found;
  cell_ctl_t               ctl;

  logic [KEY_BITS-1:0]     cell_key  [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]    hit;

  assign cmd    = cmd_t'(in_if.cmd);
  assign accept = in_if.valid && in_if.ready;
  assign empty  = (count_r == '0);
  assign full   = (count_r == CW'(QUEUE_DEPTH));
  assign found  = hit[QUEUE_DEPTH];

  assign in_if.ready = !out_valid_r || out_if.ready;

  assign ctl.push_en   = accept && (cmd == CMD_PUSH);
  assign ctl.remove_en = accept && (cmd == CMD_REMOVE);
  // pop closes up from the head
  assign hit[0] = accept && (cmd == CMD_POP) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]     nb_key;
    logic [PAYLOAD_BITS-1:0] nb_data;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb_key  = '0;
      assign nb_data = '0;
    end else begin : g_mid
      assign nb_key  = cell_key[i+1];
      assign nb_data = cell_data[i+1];
    end

    fqrk_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (CW'(i) < count_r),
      .tail    (CW'(i) == count_r),
      .hit_in  (hit[i]),
      .in_key  (in_if.key_pid),
      .in_data (in_if.entry_payload),
      .nb_key  (nb_key),
      .nb_data (nb_data),
      .key_o   (cell_key[i]),
      .data_o  (cell_data[i]),
      .hit_out (hit[i+1])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    case (cmd)
      CMD_PUSH: begin
        if (full) status_nxt = ST_FULL;
        else      count_nxt  = count_r + 1'b1;
      end
      CMD_POP: begin
        if (empty) status_nxt = ST_EMPTY;
        else       count_nxt  = count_r - 1'b1;
      end
      CMD_REMOVE: begin
        if (empty)       status_nxt = ST_EMPTY;
        else if (!found) status_nxt = ST_NOKEY;
        else             count_nxt  = count_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      if (accept) begin
        count_r  <= count_nxt;
        status_r <= status_nxt;
      end
      if (accept)             out_valid_r <= 1'b1;
      else if (out_if.ready)  out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = status_r;
  assign out_if.occupancy  = count_r;
  assign out_if.head_valid = !empty;
  assign out_if.head_key   = empty ? '0 : cell_key[0];
  assign out_if.head_data  = empty ? '0 : cell_data[0];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("occupancy moved without an item");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push_en && full |=> count_r == CW'(QUEUE_DEPTH) && status_r == ST_FULL)
    else $error("push on full queue altered the queue");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_EMPTY |-> count_r == '0)
    else $error("empty status with entries held");

  a_nokey_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.remove_en && !empty && !found |=> $stable(count_r) && status_r == ST_NOKEY)
    else $error("missed remove changed occupancy");
`endif

endmodule
